@@ hdl/rct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the reference-count table.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 16;
  localparam int ID_W       = 32;
  localparam int REF_W      = 17;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic signed [REF_W-1:0] REF_NONE = '1;  // -1: identifier absent

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // request broadcast to every slot
  typedef struct packed {
    logic             upd;     // request leaves the input stage this cycle
    logic [1:0]       action;
    logic [ID_W-1:0]  id;
  } rct_req_t;

  // count to 17-bit signed result field (zero-extend or truncate)
  function automatic logic signed [REF_W-1:0] to_ref(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+REF_W-1:0] tmp;
    tmp = (COUNT_BITS + REF_W)'(c);
    return signed'(tmp[REF_W-1:0]);
  endfunction

endpackage

@@ hdl/rct_slot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_slot
// One table slot: valid bit, identifier, count, match compare and update.
// ----------------------------------------------------------------------------
module rct_slot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rct_pkg::rct_req_t              req_i,
  input  logic                           alloc_i,  // insert here (no hit anywhere)
  output logic                           hit_o,
  output logic                           valid_o,
  output logic [rct_pkg::COUNT_BITS-1:0] count_o
);
  import rct_pkg::*;

  logic                  valid_q, valid_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  assign hit_o   = valid_q && (id_q == req_i.id);
  assign valid_o = valid_q;
  assign count_o = count_q;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    count_d = count_q;
    if (req_i.upd) begin
      case (req_i.action)
        ACT_ADD: begin
          if (hit_o) begin
            if (count_q != COUNT_MAX) count_d = count_q + COUNT_ONE;
          end else if (alloc_i) begin
            valid_d = 1'b1;
            id_d    = req_i.id;
            count_d = COUNT_ONE;
          end
        end
        ACT_RELEASE: begin
          if (hit_o) begin
            if (count_q <= COUNT_ONE) begin
              valid_d = 1'b0;
              count_d = '0;
            end else begin
              count_d = count_q - COUNT_ONE;
            end
          end
        end
        default: ;  // query and the unused code: no change
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    count_q <= count_d;
  end

endmodule

@@ hdl/refcount_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcount_table_core
// Associative reference-count table keyed by a 32-bit resource id.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+----------------------------------
//  in       | in_valid_i / in_ready_o    | action_i, resource_id_i
//  out      | out_valid_o / out_ready_i  | status_o, ref_count_o, released_o
//
//  One request per cycle sustained unless the output stalls. A request sits
//  in the input register, where all slots are compared in parallel and
//  updated, and its result is loaded into the output register at the same
//  edge. Table writes land at that edge, so the next request already sees
//  them. Reset clears the slot valid bits only; no clearing pass is needed.
//  A stalled output holds the input stage, which then drops in_ready_o.
// ----------------------------------------------------------------------------
module refcount_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [rct_pkg::ID_W-1:0]          resource_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [rct_pkg::REF_W-1:0]  ref_count_o,
  output logic                              released_o
);
  import rct_pkg::*;

  // input stage
  logic            s1_valid_q;
  logic [1:0]      act_q;
  logic [ID_W-1:0] id_q;
  logic            s1_adv;

  // result register
  logic                    ov_q;
  logic [1:0]              st_q, st_d;
  logic signed [REF_W-1:0] rc_q, rc_d;
  logic                    rel_q, rel_d;

  // slot array signals
  rct_req_t              req;
  logic [ENTRIES-1:0]    hit_vec, valid_vec, free_vec, first_free, alloc_vec;
  logic [COUNT_BITS-1:0] cnt_vec [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_sel;
  logic                  any_hit, full;

  // Stage advances when the result register is empty or being drained.
  assign s1_adv     = s1_valid_q && (!ov_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign req.upd    = s1_adv;
  assign req.action = act_q;
  assign req.id     = id_q;

  // Lowest free slot as a one-hot: isolate the least significant set bit.
  assign free_vec   = ~valid_vec;
  assign first_free = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign full       = ~|free_vec;
  assign any_hit    = |hit_vec;
  assign alloc_vec  = (act_q == ACT_ADD && !any_hit) ? first_free : '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    rct_slot u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req),
      .alloc_i (alloc_vec[g]),
      .hit_o   (hit_vec[g]),
      .valid_o (valid_vec[g]),
      .count_o (cnt_vec[g])
    );
  end

  // Ids are unique among valid slots, so at most one hit: AND-OR select.
  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cnt_sel = cnt_sel | (hit_vec[i] ? cnt_vec[i] : '0);
    end
  end

  // Result of the request in the input stage.
  always_comb begin
    st_d  = ST_OK;
    rc_d  = REF_NONE;
    rel_d = 1'b0;
    case (act_q)
      ACT_ADD: begin
        if (any_hit) begin
          rc_d = to_ref((cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + COUNT_ONE);
        end else if (full) begin
          st_d = ST_FULL;
        end else begin
          rc_d = to_ref(COUNT_ONE);
        end
      end
      ACT_RELEASE: begin
        if (!any_hit) begin
          st_d = ST_NOT_FOUND;
        end else if (cnt_sel <= COUNT_ONE) begin
          rc_d  = to_ref('0);
          rel_d = 1'b1;
        end else begin
          rc_d = to_ref(cnt_sel - COUNT_ONE);
        end
      end
      default: begin  // query, and the unused code
        if (any_hit) rc_d = to_ref(cnt_sel);
        else         st_d = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_adv)           ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      id_q  <= resource_id_i;
    end
    if (s1_adv) begin
      st_q  <= st_d;
      rc_q  <= rc_d;
      rel_q <= rel_d;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign ref_count_o = rc_q;
  assign released_o  = rel_q;

endmodule

@@ hdl/rct_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks for the reference-count table, bound to the top level.
// ----------------------------------------------------------------------------
module rct_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [1:0]                        action_i,
  input logic [rct_pkg::ID_W-1:0]          resource_id_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        status_o,
  input logic signed [rct_pkg::REF_W-1:0]  ref_count_o,
  input logic                              released_o
);
  import rct_pkg::*;

  // waiting request stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(action_i)
      && $stable(resource_id_i))
    else $error("request changed while waiting");

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(ref_count_o) && $stable(released_o))
    else $error("result changed while stalled");

  // a freed entry reports count zero and ok
  a_rel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && released_o |-> status_o == ST_OK && ref_count_o == '0)
    else $error("release flag with nonzero count");

  // failures report absent and no release
  a_fail_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> ref_count_o == REF_NONE && !released_o)
    else $error("failed request carries a count");

  // live entries always hold a positive count
  a_ok_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK && !released_o |-> ref_count_o > 0)
    else $error("live entry reports non-positive count");

endmodule

bind refcount_table_core rct_checker u_rct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .action_i      (action_i),
  .resource_id_i (resource_id_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .ref_count_o   (ref_count_o),
  .released_o    (released_o)
);
